// File: rtl/core/sta_pkg.sv
// Strided tensor address generator: shared types and constants.
// Used by strided_tensor_address_gen, sta_div_step and the testbench; no dependencies.
package sta_pkg;

    localparam int MAX_DIMS     = 4;
    localparam int IDX_W        = 32;
    localparam int SIZE_W       = 16;
    localparam int OFF_W        = 41;
    localparam int ADDR_W       = 48;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int DIV_STEPS    = 4;
    localparam int DIV_CHUNKS   = IDX_W / DIV_STEPS;
    localparam int NUM_DIVS     = 3;
    localparam int STG_DIV_LAST = NUM_DIVS * DIV_CHUNKS;
    localparam int STG_MAP      = STG_DIV_LAST + 1;
    localparam int STG_SUM      = STG_DIV_LAST + 2;
    localparam int STG_OFF      = STG_DIV_LAST + 3;
    localparam int STG_OUT      = STG_DIV_LAST + 4;
    localparam int NUM_STG      = STG_OUT + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_SIZES   = 3'd0,
        REG_DIM_STRIDES = 3'd1,
        REG_RANK        = 3'd2,
        REG_ELEM_BYTES  = 3'd3,
        REG_BASE_OFFSET = 3'd4
    } cfg_reg_t;

    localparam logic ACT_FROM_INDEX = 1'b0;
    localparam logic ACT_FROM_COORD = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [IDX_W-1:0]       idx;
        logic [IDX_W-1:0]       n;
        logic [SIZE_W-1:0]      r;
        logic [3:0][SIZE_W-1:0] coord;
        logic                   oor;
        logic [IDX_W-1:0]       row;
        logic [3:0][32:0]       prod;
        logic [1:0][34:0]       psum;
        logic [OFF_W-1:0]       off;
        logic [ADDR_W-1:0]      addr;
    } pipe_t;

endpackage

// File: rtl/core/sta_div_step.sv
// One stage of the pipelined mixed-radix divider: four restoring steps.
// Depends on sta_pkg.
module sta_div_step
    import sta_pkg::*;
#(
    parameter int DIM  = 3,
    parameter bit LAST = 1'b0
)
(
    input  pipe_t             d_in,
    input  logic [SIZE_W-1:0] divisor,
    output pipe_t             d_out
);

    always_comb
    begin
        logic [SIZE_W:0]   rr;
        logic [SIZE_W-1:0] r;
        logic [IDX_W-1:0]  n;
        logic              ge;
        d_out = d_in;
        r = d_in.r;
        n = d_in.n;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            rr = {r, n[IDX_W-1]};
            ge = (rr >= {1'b0, divisor});
            if (ge)
            begin
                rr = rr - {1'b0, divisor};
            end
            r = rr[SIZE_W-1:0];
            n = {n[IDX_W-2:0], ge};
        end
        d_out.n = n;
        d_out.r = r;
        if (LAST)
        begin
            if (d_in.action == ACT_FROM_INDEX)
            begin
                d_out.coord[DIM] = r;
            end
            d_out.r = '0;
        end
    end

endmodule

// File: rtl/core/strided_tensor_address_gen.sv
// Strided tensor address generator, top level: config registers and item pipeline.
// Depends on sta_pkg and sta_div_step.
//
//   channel   handshake                  fields
//   in        in_valid / in_ready        action, linear_index, coord_0..coord_3
//   out       out_valid / out_ready      byte_address .. index_overflow
//   cfg       cfg_wr_en (no wait)        cfg_index, cfg_wdata
//
// One item per cycle while out_ready stays high; a load stage, the 24-stage divider
// (three 32/16 divisions, 4 quotient bits per stage), then map/sum/offset/output.
// Every stage stalls only when it holds an item and the next one is blocked.
// Reset clears valid bits and config (elem_bytes resets to 4).
module strided_tensor_address_gen
    import sta_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [IDX_W-1:0]      linear_index,
    input  logic [SIZE_W-1:0]     coord_0,
    input  logic [SIZE_W-1:0]     coord_1,
    input  logic [SIZE_W-1:0]     coord_2,
    input  logic [SIZE_W-1:0]     coord_3,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADDR_W-1:0]     byte_address,
    output logic [OFF_W-1:0]      element_offset,
    output logic [IDX_W-1:0]      row_major_index,
    output logic [SIZE_W-1:0]     out_coord_0,
    output logic [SIZE_W-1:0]     out_coord_1,
    output logic [SIZE_W-1:0]     out_coord_2,
    output logic [SIZE_W-1:0]     out_coord_3,
    output logic                  index_overflow
);

    logic [CFG_DATA_W-1:0] sizes_reg;
    logic [CFG_DATA_W-1:0] strides_reg;
    logic [2:0]            rank_reg;
    logic [3:0]            elem_bytes_reg;
    logic [31:0]           base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sizes_reg      <= '0;
            strides_reg    <= '0;
            rank_reg       <= '0;
            elem_bytes_reg <= 4'd4;
            base_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DIM_SIZES:   sizes_reg      <= cfg_wdata;
                REG_DIM_STRIDES: strides_reg    <= cfg_wdata;
                REG_RANK:        rank_reg       <= cfg_wdata[2:0];
                REG_ELEM_BYTES:  elem_bytes_reg <= cfg_wdata[3:0];
                REG_BASE_OFFSET: base_reg       <= cfg_wdata[31:0];
                default:         ;
            endcase
        end
    end

    logic [2:0]              eff_rank;
    logic [3:0]              used;
    logic [3:0][SIZE_W-1:0]  sz_eff;
    logic [3:0][SIZE_W-1:0]  stride;
    logic                    zero_used;

    always_comb
    begin
        eff_rank = (rank_reg > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : rank_reg;
        zero_used = 1'b0;
        for (int d = 0; d < 4; d++)
        begin
            used[d]   = (3'(d) < eff_rank);
            stride[d] = strides_reg[d*SIZE_W +: SIZE_W];
            sz_eff[d] = used[d] ? sizes_reg[d*SIZE_W +: SIZE_W] : SIZE_W'(1);
            if (used[d] && sizes_reg[d*SIZE_W +: SIZE_W] == '0)
            begin
                zero_used = 1'b1;
            end
        end
    end

    pipe_t stg_reg   [NUM_STG];
    pipe_t stg_next  [NUM_STG];
    logic  valid_reg [NUM_STG];
    logic  rdy       [NUM_STG+1];

    assign rdy[NUM_STG] = out_ready;
    assign in_ready     = rdy[0];

    genvar k;
    generate
        for (k = 0; k < NUM_STG; k++)
        begin : g_stg
            assign rdy[k] = !valid_reg[k] || rdy[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (rdy[k])
                begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k])
                begin
                    stg_reg[k] <= stg_next[k];
                end
            end

            if (k == 0)
            begin : g_load
                always_comb
                begin
                    logic [3:0][SIZE_W-1:0] c;
                    c = {coord_3, coord_2, coord_1, coord_0};
                    stg_next[k]        = '0;
                    stg_next[k].action = action;
                    stg_next[k].idx    = linear_index;
                    stg_next[k].n      = linear_index;
                    for (int d = 0; d < 4; d++)
                    begin
                        stg_next[k].coord[d] =
                            (action == ACT_FROM_COORD && used[d]) ? c[d] : '0;
                    end
                end
            end
            else if (k <= STG_DIV_LAST)
            begin : g_div
                localparam int DIM = 3 - (k - 1) / DIV_CHUNKS;
                sta_div_step #(
                    .DIM  (DIM),
                    .LAST ((k % DIV_CHUNKS) == 0)
                ) u_div (
                    .d_in    (stg_reg[k-1]),
                    .divisor (sz_eff[DIM]),
                    .d_out   (stg_next[k])
                );
            end
            else if (k == STG_MAP)
            begin : g_map
                always_comb
                begin
                    pipe_t p;
                    p = stg_reg[k-1];
                    if (p.action == ACT_FROM_INDEX)
                    begin
                        p.coord[0] = p.n[SIZE_W-1:0];
                        p.oor = zero_used || (p.n >= {16'b0, sz_eff[0]});
                        if (p.oor)
                        begin
                            p.coord = '0;
                        end
                        p.row = p.idx;
                    end
                    else
                    begin
                        p.oor = 1'b0;
                        p.row = p.coord[0] * sz_eff[1] + {16'b0, p.coord[1]};
                    end
                    for (int d = 0; d < 4; d++)
                    begin
                        p.prod[d] = 33'($signed({1'b0, p.coord[d]}) * $signed(stride[d]));
                    end
                    stg_next[k] = p;
                end
            end
            else if (k == STG_SUM)
            begin : g_sum
                always_comb
                begin
                    pipe_t p;
                    logic [47:0] t;
                    p = stg_reg[k-1];
                    p.psum[0] = 35'($signed(p.prod[0])) + 35'($signed(p.prod[1]));
                    p.psum[1] = 35'($signed(p.prod[2])) + 35'($signed(p.prod[3]));
                    t = p.row * sz_eff[2];
                    if (p.action == ACT_FROM_COORD)
                    begin
                        p.row = t[31:0] + {16'b0, p.coord[2]};
                    end
                    stg_next[k] = p;
                end
            end
            else if (k == STG_OFF)
            begin : g_off
                always_comb
                begin
                    pipe_t p;
                    logic [47:0] t;
                    p = stg_reg[k-1];
                    p.off = 41'($signed(p.psum[0])) + 41'($signed(p.psum[1]));
                    t = p.row * sz_eff[3];
                    if (p.action == ACT_FROM_COORD)
                    begin
                        p.row = t[31:0] + {16'b0, p.coord[3]};
                    end
                    stg_next[k] = p;
                end
            end
            else
            begin : g_out
                always_comb
                begin
                    pipe_t p;
                    logic [ADDR_W-1:0] off48;
                    p = stg_reg[k-1];
                    off48 = 48'($signed(p.off));
                    p.addr = 48'({16'b0, base_reg} + 48'(off48 * {44'b0, elem_bytes_reg}));
                    if (p.oor)
                    begin
                        p.addr = '0;
                        p.off  = '0;
                        p.row  = '0;
                    end
                    stg_next[k] = p;
                end
            end
        end
    endgenerate

    assign out_valid       = valid_reg[STG_OUT];
    assign byte_address    = stg_reg[STG_OUT].addr;
    assign element_offset  = stg_reg[STG_OUT].off;
    assign row_major_index = stg_reg[STG_OUT].row;
    assign out_coord_0     = stg_reg[STG_OUT].coord[0];
    assign out_coord_1     = stg_reg[STG_OUT].coord[1];
    assign out_coord_2     = stg_reg[STG_OUT].coord[2];
    assign out_coord_3     = stg_reg[STG_OUT].coord[3];
    assign index_overflow  = stg_reg[STG_OUT].oor;

endmodule

// File: rtl/core/sta_checker.sv
// Port-level checks on the output channel of strided_tensor_address_gen.
// No package dependency; bound to the top level at the end of this file.
module sta_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [47:0] byte_address,
    input logic [40:0] element_offset,
    input logic [31:0] row_major_index,
    input logic [15:0] out_coord_0,
    input logic [15:0] out_coord_1,
    input logic [15:0] out_coord_2,
    input logic [15:0] out_coord_3,
    input logic        index_overflow
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_address)
            && $stable(row_major_index) && $stable(index_overflow))
        else $error("output item changed while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_overflow |-> byte_address == '0
            && element_offset == '0 && row_major_index == '0)
        else $error("out-of-range item carries nonzero address");

    a_oor_coord: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_overflow |-> out_coord_0 == '0 && out_coord_1 == '0
            && out_coord_2 == '0 && out_coord_3 == '0)
        else $error("out-of-range item carries nonzero coordinates");

endmodule

bind strided_tensor_address_gen sta_checker u_sta_checker (.*);

// File: tb/sv/strided_tensor_address_gen_test.sv
// Self-checking testbench for strided_tensor_address_gen: a directed table
// followed by random items across several register settings. Depends on sta_pkg.
module strided_tensor_address_gen_test;
    import sta_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [OFF_W-1:0]  off;
        logic [IDX_W-1:0]  row;
        logic [3:0][SIZE_W-1:0] crd;
        logic              oor;
    } addr_result_t;

    typedef struct packed {
        logic              act;
        logic [IDX_W-1:0]  idx;
        logic [3:0][SIZE_W-1:0] crd;
    } addr_request_t;

    typedef struct {
        addr_request_t req;
        logic          has_exp;
        addr_result_t  exp;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    cfg_reg_t cfg_index = REG_DIM_SIZES;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic action = 1'b0;
    logic [IDX_W-1:0] linear_index = '0;
    logic [SIZE_W-1:0] coord_0 = '0, coord_1 = '0, coord_2 = '0, coord_3 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ADDR_W-1:0] byte_address;
    logic [OFF_W-1:0] element_offset;
    logic [IDX_W-1:0] row_major_index;
    logic [SIZE_W-1:0] out_coord_0, out_coord_1, out_coord_2, out_coord_3;
    logic index_overflow;

    logic [63:0] sizes_q = '0;
    logic [63:0] strides_q = '0;
    logic [2:0]  rank_q = '0;
    logic [3:0]  ebytes_q = 4'd4;
    logic [31:0] base_q = '0;

    addr_result_t expected_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    strided_tensor_address_gen u_dut (.*, .cfg_index(cfg_index));

    always #5 clk = ~clk;

    function automatic addr_result_t compute_address(addr_request_t rq);
        addr_result_t res;
        int unsigned nd;
        logic [63:0] count, idx, prod, row;
        logic signed [63:0] offs, strd;
        logic [63:0] sz;
        res = '0;
        nd = (rank_q > 3'd4) ? 4 : rank_q;
        offs = 0;
        row = 0;
        if (rq.act == ACT_FROM_INDEX)
        begin
            count = 1;
            for (int d = 0; d < nd; d++)
                count = count * sizes_q[16*d +: 16];
            idx = 64'(rq.idx);
            if (idx >= count)
            begin
                res.oor = 1'b1;
                return res;
            end
            row = idx;
            for (int d = nd - 1; d >= 0; d--)
            begin
                sz = 64'(sizes_q[16*d +: 16]);
                res.crd[d] = 16'(idx % sz);
                idx = idx / sz;
            end
        end
        else
        begin
            prod = 1;
            for (int d = 0; d < nd; d++)
                res.crd[d] = rq.crd[d];
            for (int d = nd - 1; d >= 0; d--)
            begin
                row = row + prod * 64'(res.crd[d]);
                prod = prod * sizes_q[16*d +: 16];
            end
        end
        for (int d = 0; d < nd; d++)
        begin
            strd = $signed(strides_q[16*d +: 16]);
            offs = offs + $signed({48'd0, res.crd[d]}) * strd;
        end
        res.addr = 48'(64'(base_q) + 64'(ebytes_q) * offs);
        res.off = offs[OFF_W-1:0];
        res.row = row[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        addr_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected item", '0, '0);
            else
            begin
                e = expected_q.pop_front();
                if (byte_address !== e.addr)
                    report_mismatch("byte_address", 64'(byte_address), 64'(e.addr));
                if (element_offset !== e.off)
                    report_mismatch("element_offset", 64'(element_offset), 64'(e.off));
                if (row_major_index !== e.row)
                    report_mismatch("row_major_index", 64'(row_major_index), 64'(e.row));
                if (out_coord_0 !== e.crd[0])
                    report_mismatch("out_coord_0", 64'(out_coord_0), 64'(e.crd[0]));
                if (out_coord_1 !== e.crd[1])
                    report_mismatch("out_coord_1", 64'(out_coord_1), 64'(e.crd[1]));
                if (out_coord_2 !== e.crd[2])
                    report_mismatch("out_coord_2", 64'(out_coord_2), 64'(e.crd[2]));
                if (out_coord_3 !== e.crd[3])
                    report_mismatch("out_coord_3", 64'(out_coord_3), 64'(e.crd[3]));
                if (index_overflow !== e.oor)
                    report_mismatch("index_overflow", 64'(index_overflow), 64'(e.oor));
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(cfg_reg_t r, logic [63:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (r)
            REG_DIM_SIZES:   sizes_q = v;
            REG_DIM_STRIDES: strides_q = v;
            REG_RANK:        rank_q = v[2:0];
            REG_ELEM_BYTES:  ebytes_q = v[3:0];
            REG_BASE_OFFSET: base_q = v[31:0];
            default:         ;
        endcase
    endtask

    // called at a falling edge; drops valid and waits for every result
    task automatic hold_until_empty();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (35) @(posedge clk);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    // with valid still high, so the next item can follow with no gap
    task automatic send_item(addr_request_t rq, logic has_exp, addr_result_t want);
        addr_result_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        p = compute_address(rq);
        if (has_exp && p !== want)
            report_mismatch("table row", 64'(p.addr), 64'(want.addr));
        action <= rq.act;
        linear_index <= rq.idx;
        {coord_3, coord_2, coord_1, coord_0} <= rq.crd;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(has_exp ? want : p);
        @(negedge clk);
    endtask

    function automatic addr_request_t random_request();
        addr_request_t rq;
        logic [63:0] count;
        int unsigned nd;
        rq.act = 1'($urandom_range(1));
        rq.crd = {$urandom, $urandom};
        nd = (rank_q > 3'd4) ? 4 : rank_q;
        count = 1;
        for (int d = 0; d < nd; d++)
            count = count * sizes_q[16*d +: 16];
        case ($urandom_range(3))
            0: rq.idx = $urandom;
            1: rq.idx = (count == 0) ? 0 : 32'(count - 1);
            default: rq.idx = (count == 0) ? $urandom
                              : 32'({$urandom, $urandom}
                                    % (count > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : count));
        endcase
        if (rq.act == ACT_FROM_COORD && $urandom_range(1))
            for (int d = 0; d < 4; d++)
                if (sizes_q[16*d +: 16] != 0)
                    rq.crd[d] = 16'($urandom_range(sizes_q[16*d +: 16] - 1));
        return rq;
    endfunction

    table_row_t dir_rows[$];

    task automatic add_row(logic act, logic [31:0] idx, logic [63:0] crd,
                           logic has_exp, addr_result_t want);
        table_row_t t;
        t.req = '{act, idx, crd};
        t.has_exp = has_exp;
        t.exp = want;
        dir_rows.push_back(t);
    endtask

    initial
    begin
        addr_result_t z;
        addr_result_t oor_res;
        z = '0;
        oor_res = '0;
        oor_res.oor = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // rank 0 after reset: count is one
        add_row(ACT_FROM_INDEX, 32'd0, 64'd0, 1'b1, z);
        add_row(ACT_FROM_INDEX, 32'd1, 64'd0, 1'b1, oor_res);
        add_row(ACT_FROM_INDEX, 32'hFFFF_FFFF, 64'd0, 1'b1, oor_res);
        add_row(ACT_FROM_COORD, 32'd5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, z);
        foreach (dir_rows[i])
            send_item(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);
        dir_rows.delete();
        drain();

        write_reg(REG_DIM_SIZES, {16'd5, 16'd4, 16'd3, 16'd2});
        write_reg(REG_DIM_STRIDES, {16'hFFFF, 16'h8000, 16'h7FFF, 16'd1});
        write_reg(REG_RANK, 64'd7);
        write_reg(REG_ELEM_BYTES, 64'd8);
        write_reg(REG_BASE_OFFSET, 64'hFFFF_FFFF);
        add_row(ACT_FROM_INDEX, 32'd0, 64'd0, 1'b0, z);
        add_row(ACT_FROM_INDEX, 32'd119, 64'd0, 1'b0, z);
        add_row(ACT_FROM_INDEX, 32'd120, 64'd0, 1'b1, oor_res);
        add_row(ACT_FROM_INDEX, 32'd57, 64'd0, 1'b0, z);
        add_row(ACT_FROM_COORD, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, z);
        add_row(ACT_FROM_COORD, 32'hFFFF_FFFF, {16'd4, 16'd3, 16'd2, 16'd1}, 1'b0, z);
        add_row(ACT_FROM_COORD, 32'd0, 64'h8000_8000_8000_8000, 1'b0, z);
        foreach (dir_rows[i])
            send_item(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);
        dir_rows.delete();
        drain();

        // zero size in a used dimension, zero element size
        write_reg(REG_DIM_SIZES, {16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF});
        write_reg(REG_ELEM_BYTES, 64'd0);
        add_row(ACT_FROM_INDEX, 32'd0, 64'd0, 1'b1, oor_res);
        add_row(ACT_FROM_INDEX, 32'hFFFF_FFFF, 64'd0, 1'b1, oor_res);
        add_row(ACT_FROM_COORD, 32'd0, 64'hFFFF_0001_FFFF_FFFF, 1'b0, z);
        foreach (dir_rows[i])
            send_item(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);
        dir_rows.delete();
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 3)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: write_reg(REG_DIM_SIZES, 64'hFFFF_FFFF_FFFF_FFFF);
                3: write_reg(REG_DIM_SIZES, 64'd0);
                default: write_reg(REG_DIM_SIZES,
                    {16'($urandom_range(1, 40)), 16'($urandom_range(1, 300)),
                     16'($urandom_range(0, 20)), 16'($urandom_range(1, 65535))});
            endcase
            write_reg(REG_DIM_STRIDES, {$urandom, $urandom});
            write_reg(REG_RANK, (ph == 0) ? 64'd4 : 64'($urandom_range(0, 7)));
            write_reg(REG_ELEM_BYTES, (ph == 0) ? 64'd15 : 64'($urandom_range(0, 15)));
            write_reg(REG_BASE_OFFSET, (ph == 1) ? 64'd0 : 64'($urandom));
            for (int k = 0; k < 100; k++)
            begin
                send_item(random_request(), 1'b0, z);
                if (k == 50)
                    hold_until_empty();
            end
            drain();
        end

        if (errors == 0)
            $display("strided_tensor_address_gen_test passed");
        else
            $display("strided_tensor_address_gen_test failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("strided_tensor_address_gen_test failed");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/sta_pkg.sv
rtl/core/sta_div_step.sv
rtl/core/strided_tensor_address_gen.sv
rtl/core/sta_checker.sv
tb/sv/strided_tensor_address_gen_test.sv
